### rtl/core/i2cbs_pkg.sv
// shared types, command codes and step tables for the i2c bit sequencer
`default_nettype none

package i2cbs_pkg;

  // command codes, also the sequencer state (idle when no command runs)
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_RECV  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;
  localparam logic [2:0] OP_RSVD  = 3'd7;

  // register map
  localparam int unsigned AddrWidth = 3;
  localparam logic REG_STEP_TICKS = 1'b0;

  // one input tick
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  // one result per tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } res_item_t;

  // number of line steps in each command
  function automatic logic [4:0] seq_len(input logic [2:0] op);
    logic [4:0] len;
    unique case (op)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_SEND:  len = 5'd24;
      OP_RECV:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/core/i2cbs_if.sv
// valid/ready channel interfaces for the tick input and the result output
`default_nettype none

interface i2cbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, action, tx_byte, ack_level, sda_in, input ready);
  modport sink (input valid, action, tx_byte, ack_level, sda_in, output ready);
endinterface

interface i2cbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                ack_seen, rejected, output ready);
endinterface

`default_nettype wire

### rtl/core/i2cbs_regs.sv
// apb configuration register block holding step_ticks
`default_nettype none

module i2cbs_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [i2cbs_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output logic      [15:0]                    step_ticks_o
);

  logic [15:0] step_ticks_q;
  logic        wr_en;
  logic        sel_step;

  // word select ignores the byte offset bits
  assign sel_step = (paddr[2] == i2cbs_pkg::REG_STEP_TICKS);
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= 16'd1;
    end else if (wr_en && sel_step) begin
      step_ticks_q <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (sel_step) begin
      prdata = {16'd0, step_ticks_q};
    end
  end

  assign step_ticks_o = step_ticks_q;

endmodule

`default_nettype wire

### rtl/core/i2cbs_seq.sv
// line step sequencer: command state, tick timer, shift registers and line drive
`default_nettype none

module i2cbs_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_en_i,
  input  wire i2cbs_pkg::in_item_t  item_i,
  input  wire logic [15:0]          step_ticks_i,
  output i2cbs_pkg::res_item_t      res_o
);

  logic [2:0]  op_q, op_d;
  logic [4:0]  si_q, si_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  // position inside the three-step bit slot of send and receive byte
  logic [1:0]  ph_q, ph_d;
  logic [2:0]  bit_q, bit_d;

  logic [2:0]  act;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [1:0]  ph_inc;
  logic [2:0]  bit_inc;
  logic        run;
  logic        done;
  logic        rej;
  logic [7:0]  rx_out;
  logic        ack_out;

  assign act      = (item_i.action == i2cbs_pkg::OP_RSVD) ? i2cbs_pkg::OP_IDLE
                                                          : item_i.action;
  assign limit    = (step_ticks_i == 16'd0) ? 16'd1 : step_ticks_i;
  assign tick_inc = tick_q + 16'd1;
  assign ph_inc   = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
  assign bit_inc  = (ph_q == 2'd2) ? bit_q + 3'd1 : bit_q;

  // next state for one tick
  always_comb begin
    op_d    = op_q;
    si_d    = si_q;
    tick_d  = tick_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ph_d    = ph_q;
    bit_d   = bit_q;
    run     = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;
    rx_out  = 8'd0;
    ack_out = 1'b0;

    if (op_q != i2cbs_pkg::OP_IDLE) begin
      // busy: count ticks, advance one step at the end of each wait
      rej    = (act != i2cbs_pkg::OP_IDLE);
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = 16'd0;
        si_d   = si_q + 5'd1;
        ph_d   = ph_inc;
        bit_d  = bit_inc;
        if (si_d >= i2cbs_pkg::seq_len(op_q)) begin
          done = 1'b1;
          if (op_q == i2cbs_pkg::OP_RECV) begin
            rx_out = rx_q;
          end
          if (op_q == i2cbs_pkg::OP_RACK) begin
            ack_out = ack_q;
          end
          op_d = i2cbs_pkg::OP_IDLE;
          si_d = 5'd0;
        end else begin
          run = 1'b1;
        end
      end
    end else if (act != i2cbs_pkg::OP_IDLE) begin
      // idle: take the command and run its first step now
      op_d   = act;
      si_d   = 5'd0;
      tick_d = 16'd0;
      ph_d   = 2'd0;
      bit_d  = 3'd0;
      if (act == i2cbs_pkg::OP_SEND) begin
        tx_d = item_i.tx_byte;
      end
      if (act == i2cbs_pkg::OP_RECV) begin
        rx_d  = 8'd0;
        // slot starts one step late, after the sda release
        ph_d  = 2'd2;
        bit_d = 3'd7;
      end
      if (act == i2cbs_pkg::OP_SACK) begin
        ack_d = item_i.ack_level;
      end
      run = 1'b1;
    end

    // line action of the step that runs on this tick
    if (run) begin
      unique case (op_d)
        i2cbs_pkg::OP_START: begin
          case (si_d)
            5'd0:    sda_d = 1'b1;
            5'd1:    scl_d = 1'b1;
            5'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end
        i2cbs_pkg::OP_STOP: begin
          case (si_d)
            5'd0:    sda_d = 1'b0;
            5'd1:    scl_d = 1'b1;
            default: sda_d = 1'b1;
          endcase
        end
        i2cbs_pkg::OP_SEND: begin
          case (ph_d)
            2'd0:    sda_d = tx_d[3'd7 - bit_d];
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
        i2cbs_pkg::OP_RECV: begin
          if (si_d == 5'd0) begin
            sda_d = 1'b1;
          end else begin
            case (ph_d)
              2'd0: scl_d = 1'b1;
              2'd1: begin
                if (item_i.sda_in) begin
                  rx_d = rx_d | (8'h80 >> bit_d);
                end
              end
              default: scl_d = 1'b0;
            endcase
          end
        end
        i2cbs_pkg::OP_SACK: begin
          case (si_d)
            5'd0:    sda_d = ack_d;
            5'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
        i2cbs_pkg::OP_RACK: begin
          case (si_d)
            5'd0:    sda_d = 1'b1;
            5'd1:    scl_d = 1'b1;
            5'd2:    ack_d = item_i.sda_in;
            default: scl_d = 1'b0;
          endcase
        end
        default: ;
      endcase
    end
  end

  // state registers, updated once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= i2cbs_pkg::OP_IDLE;
      si_q   <= 5'd0;
      tick_q <= 16'd0;
      tx_q   <= 8'd0;
      rx_q   <= 8'd0;
      ack_q  <= 1'b0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      ph_q   <= 2'd0;
      bit_q  <= 3'd0;
    end else if (step_en_i) begin
      op_q   <= op_d;
      si_q   <= si_d;
      tick_q <= tick_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      ack_q  <= ack_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      ph_q   <= ph_d;
      bit_q  <= bit_d;
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (op_d != i2cbs_pkg::OP_IDLE);
    res_o.done_res  = done;
    res_o.rx_byte   = rx_out;
    res_o.ack_seen  = ack_out;
    res_o.rejected  = rej;
  end

endmodule

`default_nettype wire

### rtl/core/i2c_master_bit_sequencer.sv
// top level of the tick driven i2c master bit sequencer
// Each accepted input transfer is one time tick and yields exactly one result transfer
// holding the SCL/SDA drive after that tick, busy, a done pulse, the received byte or ack,
// and a rejected flag for a command that arrived while busy. A new tick is taken every
// cycle: the sequencer state advances in one pass of logic between its state registers
// and the result register, so a result shows in the cycle after its tick, and the block
// stalls only while the result register is full and the sink holds ready low. A command
// occupies sequence_length * step_ticks ticks; step_ticks (APB offset 0, reset 1, zero
// means 1) sets the ticks per line step.
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  i2cbs_in_if.sink                            in_ch,
  i2cbs_out_if.source                         out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [i2cbs_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  logic [15:0]          step_ticks;
  logic                 in_xfer;
  i2cbs_pkg::in_item_t  item;
  i2cbs_pkg::res_item_t res;
  i2cbs_pkg::res_item_t res_q;
  logic                 out_valid_q;

  i2cbs_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .step_ticks_o (step_ticks)
  );

  // input payload
  always_comb begin
    item.action    = in_ch.action;
    item.tx_byte   = in_ch.tx_byte;
    item.ack_level = in_ch.ack_level;
    item.sda_in    = in_ch.sda_in;
  end

  // take a tick whenever the result register is free or drains this cycle
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  i2cbs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (in_xfer),
    .item_i       (item),
    .step_ticks_i (step_ticks),
    .res_o        (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.scl_level = res_q.scl_level;
  assign out_ch.sda_level = res_q.sda_level;
  assign out_ch.busy_res  = res_q.busy_res;
  assign out_ch.done_res  = res_q.done_res;
  assign out_ch.rx_byte   = res_q.rx_byte;
  assign out_ch.ack_seen  = res_q.ack_seen;
  assign out_ch.rejected  = res_q.rejected;

  // a finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done result while still busy");

  // received byte only shows on a done tick
  a_rx_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.rx_byte != 8'd0) |-> res_q.done_res)
    else $error("rx_byte nonzero outside done");

  // sampled ack only shows on a done tick
  a_ack_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ack_seen |-> res_q.done_res)
    else $error("ack_seen set outside done");

  // a rejected command means a command was already running
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && res.rejected |-> (res.busy_res || res.done_res))
    else $error("rejected without a running command");

endmodule

`default_nettype wire
